[rtl/lzr_pkg.sv]
// Package for the 2D Lorenzo fixed-point reconstruction core.
// Holds register indexes, widths, the controller state type and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package lzr_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BOUND_W = 63;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned CFG_AW  = 2;

  localparam logic [CFG_AW-1:0] REG_ROW_WIDTH       = 2'd0;
  localparam logic [CFG_AW-1:0] REG_POWER_BASE      = 2'd1;
  localparam logic [CFG_AW-1:0] REG_BOUND_THRESHOLD = 2'd2;
  localparam logic [CFG_AW-1:0] REG_QUANT_RADIUS    = 2'd3;

  localparam logic [BOUND_W-1:0] BOUND_TOP = {BOUND_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_POW,
    ST_MULU,
    ST_MULV,
    ST_WRITE
  } lzr_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic prep;
    logic pow_step;
    logic mul_u;
    logic mul_v;
    logic commit;
  } lzr_cmd_t;

  typedef struct packed {
    logic unpred;
    logic pow_done;
    logic out_busy;
  } lzr_status_t;

endpackage
`default_nettype wire

[rtl/lzr_if.sv]
// Request channel interfaces for the Lorenzo reconstruction core:
// input point, result point and configuration write.
// Depends on lzr_pkg for field widths.
`default_nettype none
interface lzr_in_if;
  import lzr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      start_of_field;
  logic [IDX_W-1:0]          bound_index;
  logic [CODE_W-1:0]         quant_u;
  logic [CODE_W-1:0]         quant_v;
  logic signed [VALUE_W-1:0] raw_u;
  logic signed [VALUE_W-1:0] raw_v;
  modport source (output valid, start_of_field, bound_index, quant_u, quant_v, raw_u, raw_v,
                  input ready);
  modport sink (input valid, start_of_field, bound_index, quant_u, quant_v, raw_u, raw_v,
                output ready);
endinterface

interface lzr_out_if;
  import lzr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_u;
  logic signed [VALUE_W-1:0] value_v;
  logic                      was_unpredictable;
  modport source (output valid, value_u, value_v, was_unpredictable, input ready);
  modport sink (input valid, value_u, value_v, was_unpredictable, output ready);
endinterface

interface lzr_cfg_if;
  import lzr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CFG_AW-1:0]  index;
  logic [VALUE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/lzr_ctrl.sv]
// Controller state machine of the Lorenzo reconstruction core.
// Depends on lzr_pkg for the state, command and status types.
`default_nettype none
module lzr_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lzr_pkg::lzr_status_t st,
  output lzr_pkg::lzr_cmd_t   cmd
);
  import lzr_pkg::*;

  lzr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: state_next = ST_PREP;
      ST_PREP: begin
        if (st.unpred) state_next = ST_WRITE;
        else state_next = ST_POW;
      end
      ST_POW: begin
        if (st.pow_done) state_next = ST_MULU;
      end
      ST_MULU: state_next = ST_MULV;
      ST_MULV: state_next = ST_WRITE;
      ST_WRITE: begin
        if (!st.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: cmd.read = 1'b1;
      ST_PREP: cmd.prep = 1'b1;
      ST_POW: cmd.pow_step = !st.pow_done;
      ST_MULU: cmd.mul_u = 1'b1;
      ST_MULV: cmd.mul_v = 1'b1;
      ST_WRITE: cmd.commit = !st.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/lzr_dp.sv]
// Datapath of the Lorenzo reconstruction core: configuration registers,
// line memory, neighbor registers, error-bound power unit and residual MAC.
// Depends on lzr_pkg.
`default_nettype none
module lzr_dp #(
  parameter int unsigned MAX_COLS = 4096
) (
  input  wire                          clk,
  input  wire                          rst,
  input  lzr_pkg::lzr_cmd_t            cmd,
  output lzr_pkg::lzr_status_t         st,
  input  wire                          cfg_valid,
  input  wire [lzr_pkg::CFG_AW-1:0]    cfg_index,
  input  wire [lzr_pkg::VALUE_W-1:0]   cfg_data,
  input  wire                          start_of_field,
  input  wire [lzr_pkg::IDX_W-1:0]     bound_index,
  input  wire [lzr_pkg::CODE_W-1:0]    quant_u,
  input  wire [lzr_pkg::CODE_W-1:0]    quant_v,
  input  wire [lzr_pkg::VALUE_W-1:0]   raw_u,
  input  wire [lzr_pkg::VALUE_W-1:0]   raw_v,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [lzr_pkg::VALUE_W-1:0]  value_u,
  output logic [lzr_pkg::VALUE_W-1:0]  value_v,
  output logic                         was_unpredictable
);
  import lzr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_COLS);
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  // configuration
  logic [12:0]        row_width;
  logic [4:0]         power_base;
  logic [BOUND_W-1:0] bound_threshold;
  logic [CODE_W-1:0]  quant_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= 13'd4096;
      power_base      <= 5'd2;
      bound_threshold <= BOUND_W'(1);
      quant_radius    <= 16'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_WIDTH:       row_width       <= cfg_data[12:0];
        REG_POWER_BASE:      power_base      <= cfg_data[4:0];
        REG_BOUND_THRESHOLD: bound_threshold <= cfg_data[BOUND_W-1:0];
        REG_QUANT_RADIUS:    quant_radius    <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] eff_w;
  always_comb begin
    if (row_width == 13'd0) eff_w = CW'(1);
    else if (32'(row_width) > 32'(MAX_COLS)) eff_w = CW'(MAX_COLS);
    else eff_w = CW'(row_width);
  end

  // position state
  logic [CW-1:0] column, col_cur, col_in;
  logic          past_first_row, pfr_cur, pfr_in;

  always_comb begin
    col_in = start_of_field ? '0 : column;
    pfr_in = start_of_field ? 1'b0 : past_first_row;
    if (col_in >= eff_w) begin
      col_in = '0;
      pfr_in = 1'b1;
    end
  end

  // latched item
  logic [IDX_W-1:0]   idx;
  logic [CODE_W-1:0]  q_u, q_v;
  logic [VALUE_W-1:0] r_u, r_v;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx     <= bound_index;
      q_u     <= quant_u;
      q_v     <= quant_v;
      r_u     <= raw_u;
      r_v     <= raw_v;
      col_cur <= col_in;
      pfr_cur <= pfr_in;
    end
  end

  // line memory: {u, v} per column
  logic [2*VALUE_W-1:0] line_mem [MAX_COLS];
  logic [2*VALUE_W-1:0] up;
  logic [VALUE_W-1:0]   res_u, res_v;
  logic [VALUE_W-1:0]   fin_u, fin_v;

  assign fin_u = (idx == '0) ? r_u : res_u;
  assign fin_v = (idx == '0) ? r_v : res_v;

  always_ff @(posedge clk) begin
    if (cmd.read) up <= line_mem[col_cur[AW-1:0]];
    if (cmd.commit) line_mem[col_cur[AW-1:0]] <= {fin_u, fin_v};
  end

  // neighbors and prediction
  logic [VALUE_W-1:0] left_u, left_v, diag_u, diag_v;
  logic [VALUE_W-1:0] pred_u, pred_v;
  logic               has_left;

  assign has_left = (col_cur != '0);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      pred_u <= (pfr_cur ? up[2*VALUE_W-1:VALUE_W] : '0) + (has_left ? left_u : '0)
                - ((pfr_cur && has_left) ? diag_u : '0);
      pred_v <= (pfr_cur ? up[VALUE_W-1:0] : '0) + (has_left ? left_v : '0)
                - ((pfr_cur && has_left) ? diag_v : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_u         <= '0;
      left_v         <= '0;
      diag_u         <= '0;
      diag_v         <= '0;
      column         <= '0;
      past_first_row <= 1'b0;
    end else if (cmd.commit) begin
      left_u <= fin_u;
      left_v <= fin_v;
      diag_u <= up[2*VALUE_W-1:VALUE_W];
      diag_v <= up[VALUE_W-1:0];
      if (col_cur + CW'(1) >= eff_w) begin
        column         <= '0;
        past_first_row <= 1'b1;
      end else begin
        column         <= col_cur + CW'(1);
        past_first_row <= pfr_cur;
      end
    end
  end

  // error-bound power: four factors of the base per step, then singles
  logic [9:0]         base_sq;
  logic [19:0]        base_quad;
  logic [BOUND_W-1:0] eb;
  logic [IDX_W-1:0]   rem;
  logic               use_quad;
  logic [19:0]        factor;
  logic [BOUND_W+19:0] eb_prod;

  assign use_quad = (rem >= IDX_W'(4));
  assign factor   = use_quad ? base_quad : 20'(power_base);
  assign eb_prod  = (BOUND_W+20)'(eb) * (BOUND_W+20)'(factor);

  always_ff @(posedge clk) begin
    if (cmd.read) base_sq <= 10'(power_base) * 10'(power_base);
    if (cmd.prep) begin
      base_quad <= 20'(base_sq) * 20'(base_sq);
      eb        <= bound_threshold;
      rem       <= idx;
    end else if (cmd.pow_step) begin
      if (power_base == 5'd0) begin
        eb <= '0;
      end else if (eb_prod > (BOUND_W+20)'(BOUND_TOP)) begin
        eb <= BOUND_TOP;
      end else begin
        eb <= eb_prod[BOUND_W-1:0];
      end
      rem <= rem - (use_quad ? IDX_W'(4) : IDX_W'(1));
    end
  end

  // residual multiply-accumulate, shared between components
  logic signed [CODE_W:0]    delta;
  logic signed [CODE_W+BOUND_W+1:0] resid;

  assign delta = $signed({1'b0, (cmd.mul_u ? q_u : q_v)}) - $signed({1'b0, quant_radius});
  assign resid = (CODE_W+BOUND_W+2)'(delta) * (CODE_W+BOUND_W+2)'($signed({1'b0, eb}));

  always_ff @(posedge clk) begin
    if (cmd.mul_u) res_u <= pred_u + {resid[VALUE_W-2:0], 1'b0};
    if (cmd.mul_v) res_v <= pred_v + {resid[VALUE_W-2:0], 1'b0};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      value_u           <= fin_u;
      value_v           <= fin_v;
      was_unpredictable <= (idx == '0);
    end
  end

  // a base of one leaves the bound as it is, so skip the loop
  assign st.unpred   = (idx == '0);
  assign st.pow_done = (rem == '0) || (eb == '0) || (eb == BOUND_TOP)
                       || (power_base == 5'd1);
  assign st.out_busy = out_valid && !out_ready;

endmodule
`default_nettype wire

[rtl/lorenzo_2d_fixed_reconstruct_core.sv]
// Top level of the 2D Lorenzo fixed-point reconstruction core.
// Joins lzr_ctrl and lzr_dp; depends on lzr_pkg and the lzr_if interfaces.
//
//   channel   dir   payload                                         notes
//   in_chan   in    start_of_field, bound_index, quant_u/v, raw_u/v  one grid point
//   out_chan  out   value_u, value_v, was_unpredictable             one per point
//   cfg       in    index (2 b), data (64 b)                         always ready
//
// One point at a time. An unpredictable point runs the read, prep and write
// steps; a predicted point runs read, prep, P power steps, multiply u,
// multiply v and write. P is one step per four factors of the base, then
// single factors, cut short once the bound saturates, reaches zero or the
// base is one (P is at most 18, reached with base 2, threshold 1 and index 63).
// The write step loads the result register, and the next request is taken
// after it; the power loop sets the rate. Reset is synchronous and clears
// control, neighbors and position; the line memory is not cleared. A stalled
// result holds the block in its write step; the next request is taken while
// a result waits.
`default_nettype none
module lorenzo_2d_fixed_reconstruct_core #(
  parameter int unsigned MAX_COLS = 4096
) (
  input wire        clk,
  input wire        rst,
  lzr_in_if.sink    in_chan,
  lzr_out_if.source out_chan,
  lzr_cfg_if.sink   cfg
);
  import lzr_pkg::*;

  lzr_cmd_t    cmd;
  lzr_status_t st;
  logic        in_ready;

  assign in_chan.ready = in_ready;
  // the user must change configuration only while idle (not enforced here), so take every write at once
  assign cfg.ready = 1'b1;

  lzr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lzr_dp #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .cfg_valid         (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .start_of_field    (in_chan.start_of_field),
    .bound_index       (in_chan.bound_index),
    .quant_u           (in_chan.quant_u),
    .quant_v           (in_chan.quant_v),
    .raw_u             (in_chan.raw_u),
    .raw_v             (in_chan.raw_v),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .value_u           (out_chan.value_u),
    .value_v           (out_chan.value_v),
    .was_unpredictable (out_chan.was_unpredictable)
  );

`ifndef NO_ASSERTIONS
  // one point in flight: an accepted request closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while a point was in flight");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_chan.valid && !out_chan.ready))
    else $error("result committed over a pending result");

  // a commit always presents a result next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_chan.valid)
    else $error("commit without a result");
`endif

endmodule
`default_nettype wire

[tb/tb_lorenzo_2d_fixed_reconstruct_core.sv]
// Self-checking testbench for lorenzo_2d_fixed_reconstruct_core: random and
// directed grid points against an in-bench Lorenzo reconstruction predictor.
// Depends on lzr_pkg, the lzr_if interfaces and the core RTL.
`timescale 1ns / 1ps
module tb_lorenzo_2d_fixed_reconstruct_core;
  import lzr_pkg::*;

  localparam int unsigned COLS = 4096;
  localparam logic [63:0] INT_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        sof;
    logic [9:0]  bidx;
    logic [15:0] qu;
    logic [15:0] qv;
    logic [63:0] ru;
    logic [63:0] rv;
  } point_t;

  typedef struct {
    logic [63:0] vu;
    logic [63:0] vv;
    logic        unpred;
  } recon_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzr_in_if  in_chan ();
  lzr_out_if out_chan ();
  lzr_cfg_if cfg ();

  lorenzo_2d_fixed_reconstruct_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg      (cfg)
  );

  // Points waiting to be driven, and reconstructed values waiting to arrive.
  point_t pending_points[$];
  recon_t expected_values[$];
  int     errors = 0;
  bit     presenting = 1'b0;  // a request sits on in_chan until accepted
  bit     steady = 1'b0;      // no idling on either side while set

  // Predictor copy of the registers and the neighbor state.
  logic [12:0] p_row_width = 13'd4096;
  logic [4:0]  p_base      = 5'd2;
  logic [62:0] p_threshold = 63'd1;
  logic [15:0] p_radius    = 16'd32768;
  logic [63:0] line_u[COLS];
  logic [63:0] line_v[COLS];
  logic [63:0] left_u = '0, left_v = '0, diag_u = '0, diag_v = '0;
  int unsigned col = 0;
  bit          below_first = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL lorenzo_2d_fixed_reconstruct_core");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Error bound: threshold times base^idx, saturating at the int64 top.
  function automatic logic [63:0] error_bound(input logic [9:0] idx);
    logic [63:0] eb;
    eb = {1'b0, p_threshold};
    for (int k = 0; k < idx; k++) begin
      if (eb == 0 || eb == INT_TOP) break;
      if (p_base == 0) begin
        eb = 0;
        break;
      end
      if (eb > INT_TOP / p_base) eb = INT_TOP;
      else eb = eb * p_base;
    end
    return eb;
  endfunction

  function automatic logic [63:0] rebuild(input logic [63:0] up, input logic [63:0] lf,
                                          input logic [63:0] dg, input logic [15:0] q,
                                          input logic [63:0] eb);
    logic [63:0] pred;
    logic [63:0] delta;
    pred = '0;
    delta = {48'd0, q} - {48'd0, p_radius};
    if (below_first) pred += up;
    if (col != 0) pred += lf;
    if (below_first && col != 0) pred -= dg;
    return pred + 64'd2 * delta * eb;
  endfunction

  // Advance the predictor by one accepted point.
  task automatic reconstruct_point(input point_t p, output recon_t r);
    int unsigned w;
    logic [63:0] up_u, up_v, eb;
    w = (p_row_width == 0) ? 1 : (p_row_width > COLS) ? COLS : p_row_width;
    if (p.sof) begin
      col = 0;
      below_first = 1'b0;
    end
    if (col >= w) begin
      col = 0;
      below_first = 1'b1;
    end
    up_u = line_u[col];
    up_v = line_v[col];
    if (p.bidx == 0) begin
      r.vu = p.ru;
      r.vv = p.rv;
      r.unpred = 1'b1;
    end else begin
      eb = error_bound(p.bidx);
      r.vu = rebuild(up_u, left_u, diag_u, p.qu, eb);
      r.vv = rebuild(up_v, left_v, diag_v, p.qv, eb);
      r.unpred = 1'b0;
    end
    diag_u = up_u;
    diag_v = up_v;
    left_u = r.vu;
    left_v = r.vv;
    line_u[col] = r.vu;
    line_v[col] = r.vv;
    col++;
    if (col >= w) begin
      col = 0;
      below_first = 1'b1;
    end
  endtask

  // Driver: change inputs on the falling edge; idle at random about 16 percent of the time.
  always @(negedge clk) begin
    if (rst) begin
      in_chan.valid = 1'b0;
    end else if (!presenting) begin
      if (pending_points.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
        in_chan.start_of_field = pending_points[0].sof;
        in_chan.bound_index    = pending_points[0].bidx;
        in_chan.quant_u        = pending_points[0].qu;
        in_chan.quant_v        = pending_points[0].qv;
        in_chan.raw_u          = pending_points[0].ru;
        in_chan.raw_v          = pending_points[0].rv;
        in_chan.valid          = 1'b1;
        presenting             = 1'b1;
      end else begin
        in_chan.valid = 1'b0;
      end
    end
    out_chan.ready = rst ? 1'b0 : (steady || $urandom_range(99) >= 16);
  end

  // Monitor: sample both channels on the rising edge, predict and compare.
  always @(posedge clk) begin
    point_t p;
    recon_t r;
    recon_t want;
    if (!rst && in_chan.valid && in_chan.ready) begin
      p = pending_points.pop_front();
      reconstruct_point(p, r);
      expected_values = {expected_values, r};
      presenting = 1'b0;
    end
    if (!rst && cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ROW_WIDTH:       p_row_width = cfg.data[12:0];
        REG_POWER_BASE:      p_base      = cfg.data[4:0];
        REG_BOUND_THRESHOLD: p_threshold = cfg.data[62:0];
        REG_QUANT_RADIUS:    p_radius    = cfg.data[15:0];
        default: ;
      endcase
    end
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected result", out_chan.value_u, '0);
      end else begin
        want = expected_values.pop_front();
        if (out_chan.value_u !== want.vu) report_mismatch("value_u", out_chan.value_u, want.vu);
        if (out_chan.value_v !== want.vv) report_mismatch("value_v", out_chan.value_v, want.vv);
        if (out_chan.was_unpredictable !== want.unpred)
          report_mismatch("was_unpredictable", 64'(out_chan.was_unpredictable),
                          64'(want.unpred));
      end
    end
  end

  // Write one register; only called while the core is idle.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg.index = idx;
    cfg.data  = data;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Hold the sender until every queued request has been answered.
  task automatic drain();
    while (pending_points.size() != 0 || presenting || expected_values.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic point_t random_point();
    point_t p;
    int unsigned sel;
    sel = $urandom_range(99);
    p.sof  = ($urandom_range(99) < 2);
    p.bidx = (sel < 15) ? 10'd0 : (sel < 85) ? 10'($urandom_range(1, 12))
                                               : 10'($urandom_range(1, 1023));
    p.qu = 16'($urandom);
    p.qv = 16'($urandom);
    // Keep codes near the radius most of the time so values stay moderate.
    if ($urandom_range(3) != 0) begin
      p.qu = p_radius + 16'($urandom_range(0, 8)) - 16'd4;
      p.qv = p_radius + 16'($urandom_range(0, 8)) - 16'd4;
    end
    p.ru = rand64();
    p.rv = rand64();
    return p;
  endfunction

  task automatic push_point(input logic sof, input logic [9:0] bidx, input logic [15:0] qu,
                            input logic [15:0] qv, input logic [63:0] ru,
                            input logic [63:0] rv);
    point_t p;
    p.sof = sof; p.bidx = bidx; p.qu = qu; p.qv = qv; p.ru = ru; p.rv = rv;
    pending_points = {pending_points, p};
  endtask

  // Configure the core, then queue a field. With restart set the field opens
  // with a restart, so a widened row never reads a line entry that was never written.
  task automatic run_phase(input logic [63:0] width, input logic [63:0] base,
                           input logic [63:0] thresh, input logic [63:0] radius,
                           input int n, input bit restart);
    point_t p;
    drain();
    write_reg(REG_ROW_WIDTH, width);
    write_reg(REG_POWER_BASE, base);
    write_reg(REG_BOUND_THRESHOLD, thresh);
    write_reg(REG_QUANT_RADIUS, radius);
    for (int i = 0; i < n; i++) begin
      p = random_point();
      if (i == 0) p.sof = restart;
      pending_points = {pending_points, p};
    end
  endtask

  initial begin
    logic [63:0] bases[6]  = '{64'd2, 64'd3, 64'd16, 64'd0, 64'd1, 64'd31};
    logic [63:0] widths[8] = '{64'd1, 64'd2, 64'd5, 64'd7, 64'd16, 64'd64, 64'd0, 64'd33};
    cfg.valid = 1'b0;
    cfg.index = REG_ROW_WIDTH;
    cfg.data  = '0;
    in_chan.valid = 1'b0;
    in_chan.start_of_field = 1'b0;
    in_chan.bound_index = '0;
    in_chan.quant_u = '0;
    in_chan.quant_v = '0;
    in_chan.raw_u = '0;
    in_chan.raw_v = '0;
    out_chan.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: narrow rows, pass-through extremes, saturation, code extremes.
    run_phase(64'd3, 64'd2, 64'd1, 64'd32768, 0, 1'b1);
    push_point(1'b1, 10'd0, 16'h0000, 16'hFFFF, 64'h8000_0000_0000_0000,
               64'h7FFF_FFFF_FFFF_FFFF);
    push_point(1'b0, 10'd1, 16'd32768, 16'd32769, '0, '0);
    push_point(1'b0, 10'd1023, 16'd32767, 16'd32770, '0, '0);
    push_point(1'b0, 10'd1, 16'h0000, 16'hFFFF, '0, '0);
    push_point(1'b0, 10'd0, 16'hFFFF, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    push_point(1'b0, 10'd5, 16'hFFFF, 16'h0000, rand64(), rand64());
    push_point(1'b0, 10'd62, 16'd32769, 16'd32767, '0, '0);
    push_point(1'b0, 10'd63, 16'd32769, 16'd32767, '0, '0);
    push_point(1'b0, 10'h3FF, 16'd32768, 16'd32768, '0, '0);
    push_point(1'b1, 10'd2, 16'd32770, 16'd32766, '0, '0);
    push_point(1'b0, 10'd0, 16'd1, 16'd1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    push_point(1'b0, 10'h200, 16'h8000, 16'h7FFF, '0, '0);

    // Row width shrunk mid-row: the next point starts a new row.
    run_phase(64'd7, 64'd3, 64'd5, 64'd100, 10, 1'b1);
    run_phase(64'd2, 64'd3, 64'd5, 64'd100, 6, 1'b0);

    // Width extremes: zero acts as one, all-ones acts as the full line.
    run_phase(64'd0, 64'd0, INT_TOP, 64'd1, 20, 1'b1);
    run_phase(64'h1FFF, 64'd16, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 40, 1'b1);
    run_phase(64'd4096, 64'd1, 64'd0, 64'hFFFF, 30, 1'b1);

    // Random settings; one phase runs with no idling on either side.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      steady = (ph == 4);
      run_phase(widths[$urandom_range(7)], bases[$urandom_range(5)],
                ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(0, 1000)),
                ($urandom_range(3) == 0) ? 64'($urandom) : 64'd32768,
                100, 1'b1);
    end

    drain();
    steady = 1'b0;
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS lorenzo_2d_fixed_reconstruct_core");
    end else begin
      $display("FAIL lorenzo_2d_fixed_reconstruct_core");
    end
    $finish;
  end
endmodule

[lorenzo_2d_fixed_reconstruct_core.f]
rtl/lzr_pkg.sv
rtl/lzr_if.sv
rtl/lzr_ctrl.sv
rtl/lzr_dp.sv
rtl/lorenzo_2d_fixed_reconstruct_core.sv
tb/tb_lorenzo_2d_fixed_reconstruct_core.sv
